### hw/rtl/ket_pkg.sv
// Package for the keyed entry table: defaults, operation and status codes, state type.
package ket_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned TAG_BITS_DEF    = 6;

    localparam logic [1:0] FUNC_INSERT     = 2'd0;
    localparam logic [1:0] FUNC_FIND_KEY   = 2'd1;
    localparam logic [1:0] FUNC_FIND_VALUE = 2'd2;

    localparam logic [2:0] STATUS_ADDED     = 3'd0;
    localparam logic [2:0] STATUS_UPDATED   = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_FOUND     = 3'd3;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

### hw/rtl/keyed_entry_table_insert_lookup.sv
// Keyed entry table: insert-or-update, find by key, find by value over block memories.
//
// Command in: a word (i_func, i_entry_key, i_entry_value, i_owner_tag) is taken at the
// rising edge where start is high and busy is low. busy stays high until the word is done.
// Result out: o_done is high for exactly one cycle with o_status, o_entry_index and
// o_fill_count; the receiver cannot hold it off, and a new word may start in that cycle.
// The key and value memories are read one entry per cycle from entry 0 upward; the read
// data is registered and then compared, so the scan runs at one entry per cycle.
// The scan ends at the first match or after the last filled entry; an empty table or an
// unused operation code skips the scan and goes straight to the finishing state. Words
// are handled one at a time.
// Writes (new entry or value update) take place in the final cycle, before o_done.
// Reset clears the fill count and the control state only; the memories keep their
// contents, and entries at or above the fill count are never compared.
module keyed_entry_table_insert_lookup #(
    parameter int unsigned TABLE_DEPTH = ket_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned TAG_BITS    = ket_pkg::TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_entry_key,
    input  logic [31:0] i_entry_value,
    input  logic [5:0]  i_owner_tag,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_entry_index,
    output logic [8:0]  o_fill_count
);
    import ket_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned FW = AW + 1;

    logic [31:0]         key_mem [TABLE_DEPTH];
    logic [31:0]         val_mem [TABLE_DEPTH];
    logic [TAG_BITS-1:0] tag_mem [TABLE_DEPTH];

    t_state      r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_pend, n_pend;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic [1:0]    r_func;
    logic [31:0]   r_key, r_value;
    logic [5:0]    r_tag;
    logic [31:0]   r_key_q, r_val_q;
    logic          r_done, n_done;
    logic [2:0]    r_status, n_status;
    logic [7:0]    r_index, n_index;
    logic [8:0]    r_fill_out, n_fill_out;

    logic          accept;
    logic          match;
    logic          last;
    logic          full;
    logic          we_new;
    logic          we_upd;
    logic [AW-1:0] wr_addr;
    logic [31:0]   idx_ext;
    logic [31:0]   fill_ext;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign full   = (r_fill == FW'(TABLE_DEPTH));
    assign match  = (r_func == FUNC_FIND_VALUE) ? (r_val_q == r_value) : (r_key_q == r_key);
    assign last   = (FW'(r_cmp_idx) + FW'(1)) == r_fill;

    assign we_upd  = (r_state == ST_FINISH) && (r_func == FUNC_INSERT) && r_hit;
    assign we_new  = (r_state == ST_FINISH) && (r_func == FUNC_INSERT) && !r_hit && !full;
    assign wr_addr = r_hit ? r_hit_idx : r_fill[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we_new) begin
            key_mem[wr_addr] <= r_key;
            tag_mem[wr_addr] <= TAG_BITS'(r_tag);
        end
        if (we_new || we_upd) begin
            val_mem[wr_addr] <= r_value;
        end
        r_key_q <= key_mem[r_rd_idx];
        r_val_q <= val_mem[r_rd_idx];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_fill == '0 || !(i_func == FUNC_INSERT || i_func == FUNC_FIND_KEY
                                          || i_func == FUNC_FIND_VALUE)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend && (match || last)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_fill     = r_fill;
        n_rd_idx   = r_rd_idx;
        n_cmp_idx  = r_cmp_idx;
        n_pend     = r_pend;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_done     = 1'b0;
        n_status   = r_status;
        n_index    = r_index;
        n_fill_out = r_fill_out;
        idx_ext    = 32'(r_hit_idx);
        fill_ext   = 32'(r_fill);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                end
            end
            ST_SCAN: begin
                n_rd_idx  = r_rd_idx + AW'(1);
                n_cmp_idx = r_rd_idx;
                n_pend    = 1'b1;
                if (r_pend && match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_cmp_idx;
                end
            end
            ST_FINISH: begin
                n_done = 1'b1;
                if (r_func == FUNC_INSERT) begin
                    if (r_hit) begin
                        n_status = STATUS_UPDATED;
                        n_index  = idx_ext[7:0];
                    end else if (full) begin
                        n_status = STATUS_FULL;
                        n_index  = '0;
                    end else begin
                        n_status = STATUS_ADDED;
                        n_index  = fill_ext[7:0];
                        n_fill   = r_fill + FW'(1);
                        fill_ext = 32'(r_fill) + 32'd1;
                    end
                end else if (r_hit) begin
                    n_status = STATUS_FOUND;
                    n_index  = idx_ext[7:0];
                end else begin
                    n_status = STATUS_NOT_FOUND;
                    n_index  = '0;
                end
                n_fill_out = fill_ext[8:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_status   <= n_status;
        r_index    <= n_index;
        r_fill_out <= n_fill_out;
        if (accept) begin
            r_func  <= i_func;
            r_key   <= i_entry_key;
            r_value <= i_entry_value;
            r_tag   <= i_owner_tag;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_index = r_index;
    assign o_fill_count  = r_fill_out;

`ifndef SYNTHESIS
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_FINISH))
        else $error("result word without a finishing cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_fill != $past(r_fill)) |->
            (r_fill == $past(r_fill) + FW'(1) && o_done && o_status == STATUS_ADDED))
        else $error("fill count moved without an added entry");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the keyed entry table: shadow table, stimulus and result checks.
`timescale 1ns / 1ps

import ket_pkg::*;

typedef struct packed {
    logic [2:0] status;
    logic [7:0] index;
    logic [8:0] fill;
} t_reply;

class table_shadow;
    logic [31:0] key_mem [TABLE_DEPTH_DEF];
    logic [31:0] value_mem [TABLE_DEPTH_DEF];
    logic [5:0]  tag_mem [TABLE_DEPTH_DEF];
    int          fill;
    t_reply      pending[$];
    int          status_seen[5];
    int          mismatches;

    function new();
        fill = 0;
        mismatches = 0;
        foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function int search(logic [31:0] target, bit by_value);
        for (int i = 0; i < fill; i++) begin
            if ((by_value ? value_mem[i] : key_mem[i]) == target) return i;
        end
        return -1;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_command(logic [1:0] func, logic [31:0] key, logic [31:0] value,
                               logic [5:0] tag);
        t_reply r;
        int     hit;
        r.status = STATUS_NOT_FOUND;
        r.index  = '0;
        case (func)
            FUNC_INSERT: begin
                hit = search(key, 1'b0);
                if (hit >= 0) begin
                    value_mem[hit] = value;
                    r.status = STATUS_UPDATED;
                    r.index  = hit[7:0];
                end else if (fill >= TABLE_DEPTH_DEF) begin
                    r.status = STATUS_FULL;
                end else begin
                    key_mem[fill]   = key;
                    value_mem[fill] = value;
                    tag_mem[fill]   = tag;
                    r.status = STATUS_ADDED;
                    r.index  = fill[7:0];
                    fill++;
                end
            end
            FUNC_FIND_KEY, FUNC_FIND_VALUE: begin
                hit = search(func == FUNC_FIND_KEY ? key : value, func == FUNC_FIND_VALUE);
                if (hit >= 0) begin
                    r.status = STATUS_FOUND;
                    r.index  = hit[7:0];
                end
            end
            default: ;
        endcase
        r.fill = fill[8:0];
        status_seen[r.status]++;
        pending.push_back(r);
    endfunction

    function void check_reply(logic [2:0] status, logic [7:0] index, logic [8:0] fill_val);
        t_reply got;
        t_reply want;
        got.status = status;
        got.index  = index;
        got.fill   = fill_val;
        if (pending.size() == 0) begin
            flag($sformatf("unexpected result: status %0d index %0d fill %0d",
                           status, index, fill_val));
        end else begin
            want = pending.pop_front();
            if (got != want)
                flag($sformatf({"mismatch: expected status %0d index %0d fill %0d, ",
                                "got status %0d index %0d fill %0d"},
                               want.status, want.index, want.fill,
                               got.status, got.index, got.fill));
        end
    endfunction
endclass

module testbench;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_200_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = '0;
    logic [31:0] i_entry_key = '0;
    logic [31:0] i_entry_value = '0;
    logic [5:0]  i_owner_tag = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_entry_index;
    logic [8:0]  o_fill_count;

    table_shadow shadow;
    bit          offering = 1'b0;
    int          burst_left = 1;
    int          words_sent = 0;
    int          cycles = 0;

    keyed_entry_table_insert_lookup i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_entry_key  (i_entry_key),
        .i_entry_value(i_entry_value),
        .i_owner_tag  (i_owner_tag),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_entry_index(o_entry_index),
        .o_fill_count (o_fill_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, shadow.pending.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) shadow.check_reply(o_status, o_entry_index, o_fill_count);
    end

    // word is taken at the edge where start is high and busy is low
    task automatic send_word(input logic [1:0] func, input logic [31:0] key,
                             input logic [31:0] value, input logic [5:0] tag);
        start         <= 1'b1;
        i_func        <= func;
        i_entry_key   <= key;
        i_entry_value <= value;
        i_owner_tag   <= tag;
        offering = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        shadow.note_command(func, key, value, tag);
        words_sent++;
    endtask

    task automatic hold_off();
        if (offering) begin
            start <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 280) : $urandom_range(1, 12);
            hold_off();
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic drain();
        hold_off();
        while (shadow.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic directed(input logic [1:0] func, input logic [31:0] key,
                            input logic [31:0] value, input logic [5:0] tag);
        send_word(func, key, value, tag);
        pace();
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_command(input int insert_pct, input int fresh_pct);
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
        int          roll;
        roll  = $urandom_range(0, 99);
        key   = pick_word();
        value = pick_word();
        if (roll < 3) func = FUNC_UNUSED;
        else if (roll < 3 + insert_pct) func = FUNC_INSERT;
        else if (roll % 2) func = FUNC_FIND_KEY;
        else func = FUNC_FIND_VALUE;
        if (shadow.fill > 0 && $urandom_range(0, 99) >= fresh_pct)
            key = shadow.key_mem[$urandom_range(0, shadow.fill - 1)];
        if (shadow.fill > 0 && $urandom_range(0, 99) < 40)
            value = shadow.value_mem[$urandom_range(0, shadow.fill - 1)];
        send_word(func, key, value, 6'($urandom_range(0, 63)));
        pace();
    endtask

    initial begin
        shadow = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unused code
        directed(FUNC_FIND_KEY,   32'h0000_0000, 32'h0000_0000, 6'd0);
        directed(FUNC_FIND_VALUE, 32'h0000_0000, 32'h0000_0000, 6'd0);
        directed(FUNC_UNUSED,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        // extremes, duplicate values, updates
        directed(FUNC_INSERT,     32'h0000_0000, 32'h0000_0000, 6'd0);
        directed(FUNC_INSERT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        directed(FUNC_INSERT,     32'hAAAA_AAAA, 32'h5555_5555, 6'h2A);
        directed(FUNC_INSERT,     32'h5555_5555, 32'h5555_5555, 6'h15);
        directed(FUNC_FIND_VALUE, 32'h0000_0000, 32'h5555_5555, 6'd0);
        directed(FUNC_INSERT,     32'h0000_0000, 32'h5555_5555, 6'd63);
        directed(FUNC_FIND_VALUE, 32'h0000_0000, 32'h5555_5555, 6'd0);
        directed(FUNC_FIND_KEY,   32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
        directed(FUNC_FIND_KEY,   32'h1234_5678, 32'h0000_0000, 6'd0);
        directed(FUNC_FIND_VALUE, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
        directed(FUNC_FIND_VALUE, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
        directed(FUNC_UNUSED,     32'h0000_0000, 32'h0000_0000, 6'd0);
        directed(FUNC_INSERT,     32'h5555_5555, 32'h0000_0000, 6'd0);
        directed(FUNC_FIND_KEY,   32'h0000_0000, 32'hFFFF_FFFF, 6'd63);
        directed(FUNC_FIND_VALUE, 32'hAAAA_AAAA, 32'h0000_0000, 6'd0);
        drain();

        repeat (400) random_command(40, 50);
        drain();

        // fill to capacity, then work on the full table
        while (shadow.fill < TABLE_DEPTH_DEF) random_command(80, 80);
        drain();
        directed(FUNC_INSERT, 32'h0BAD_F00D, 32'hFFFF_FFFF, 6'd63);
        directed(FUNC_INSERT, shadow.key_mem[TABLE_DEPTH_DEF - 1], 32'h0000_0000, 6'd0);
        repeat (350) random_command(35, 50);

        drain();
        repeat (8) @(posedge i_clk);

        $display("%0d words: %0d added, %0d updated, %0d full, %0d found, %0d not found",
                 words_sent, shadow.status_seen[STATUS_ADDED], shadow.status_seen[STATUS_UPDATED],
                 shadow.status_seen[STATUS_FULL], shadow.status_seen[STATUS_FOUND],
                 shadow.status_seen[STATUS_NOT_FOUND]);
        $display("table reached %0d of %0d entries; %0d mismatches in %0d cycles",
                 shadow.fill, TABLE_DEPTH_DEF, shadow.mismatches, cycles);
        if (shadow.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/ket_pkg.sv
hw/rtl/keyed_entry_table_insert_lookup.sv
tb/testbench.sv
